// ----- rtl/triangle_rectangle_overlap_test_defines.svh -----
// Assertion macros for the triangle/rectangle overlap test block.
`ifndef TRIANGLE_RECTANGLE_OVERLAP_TEST_DEFINES_SVH
`define TRIANGLE_RECTANGLE_OVERLAP_TEST_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TROV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TROV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TROV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define TROV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/trov_pkg.sv -----
// Shared constants and types for the triangle/rectangle overlap test.
package trov_pkg;

    localparam int COORD_BITS_DEFAULT = 16;

    // register stages: differences, products, sums, compare
    localparam int STAGES = 4;

    typedef struct packed {
        logic [STAGES-1:0] load;
    } trov_adv_t;

endpackage

// ----- rtl/trov_channels.sv -----
// Valid/ready channel interfaces for the overlap test input pairs and verdicts.
interface trov_pair_if #(
    parameter int COORD_BITS = trov_pkg::COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] rect_min_x;
    logic signed [COORD_BITS-1:0] rect_max_x;
    logic signed [COORD_BITS-1:0] rect_min_y;
    logic signed [COORD_BITS-1:0] rect_max_y;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, rect_min_x, rect_max_x, rect_min_y, rect_max_y,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, rect_min_x, rect_max_x, rect_min_y, rect_max_y,
        output ready
    );
endinterface

interface trov_verdict_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (
        output valid, overlap,
        input  ready
    );
    modport sink (
        input  valid, overlap,
        output ready
    );
endinterface

// ----- rtl/trov_bbox.sv -----
// Bounding-box test of the triangle against the rectangle, delayed to the pipeline depth.
module trov_bbox #(
    parameter int COORD_BITS = trov_pkg::COORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] c_x,
    input  logic signed [COORD_BITS-1:0] c_y,
    input  logic signed [COORD_BITS-1:0] x0,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y0,
    input  logic signed [COORD_BITS-1:0] y1,
    input  trov_pkg::trov_adv_t          adv,
    output logic                         ok
);

    logic [trov_pkg::STAGES-1:0] ok_reg;
    logic [trov_pkg::STAGES-1:0] ok_next;

    // min3 > bound is all three above it; max3 < bound is all three below it
    always_comb
    begin
        ok_next[0] = !((a_x > x1 && b_x > x1 && c_x > x1) ||
                       (a_x < x0 && b_x < x0 && c_x < x0) ||
                       (a_y > y1 && b_y > y1 && c_y > y1) ||
                       (a_y < y0 && b_y < y0 && c_y < y0));
        for (int k = 1; k < trov_pkg::STAGES; k++)
        begin
            ok_next[k] = ok_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < trov_pkg::STAGES; k++)
        begin
            if (adv.load[k])
            begin
                ok_reg[k] <= ok_next[k];
            end
        end
    end

    assign ok = ok_reg[trov_pkg::STAGES-1];

endmodule

// ----- rtl/trov_edge.sv -----
// Separating-axis test on one triangle edge normal: differences, products, sums, compare.
module trov_edge #(
    parameter int COORD_BITS = trov_pkg::COORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic signed [COORD_BITS-1:0] s_x,
    input  logic signed [COORD_BITS-1:0] s_y,
    input  logic signed [COORD_BITS-1:0] e_x,
    input  logic signed [COORD_BITS-1:0] e_y,
    input  logic signed [COORD_BITS-1:0] o_x,
    input  logic signed [COORD_BITS-1:0] o_y,
    input  logic signed [COORD_BITS-1:0] x0,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y0,
    input  logic signed [COORD_BITS-1:0] y1,
    input  trov_pkg::trov_adv_t          adv,
    output logic                         ok
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    // stage 0: differences relative to the edge start vertex
    logic signed [DW-1:0] nx_reg, ny_reg, rx0_reg, rx1_reg, ry0_reg, ry1_reg, tx_reg, ty_reg;
    logic signed [DW-1:0] nx_next, ny_next, rx0_next, rx1_next, ry0_next, ry1_next;
    logic signed [DW-1:0] tx_next, ty_next;

    assign nx_next  = DW'(s_y) - DW'(e_y);
    assign ny_next  = DW'(e_x) - DW'(s_x);
    assign rx0_next = DW'(x0)  - DW'(s_x);
    assign rx1_next = DW'(x1)  - DW'(s_x);
    assign ry0_next = DW'(y0)  - DW'(s_y);
    assign ry1_next = DW'(y1)  - DW'(s_y);
    assign tx_next  = DW'(o_x) - DW'(s_x);
    assign ty_next  = DW'(o_y) - DW'(s_y);

    // stage 1: projections
    logic signed [PW-1:0] px0_reg, px1_reg, py0_reg, py1_reg, ptx_reg, pty_reg;
    logic signed [PW-1:0] px0_next, px1_next, py0_next, py1_next, ptx_next, pty_next;

    assign px0_next = nx_reg * rx0_reg;
    assign px1_next = nx_reg * rx1_reg;
    assign py0_next = ny_reg * ry0_reg;
    assign py1_next = ny_reg * ry1_reg;
    assign ptx_next = nx_reg * tx_reg;
    assign pty_next = ny_reg * ty_reg;

    // stage 2: rectangle span and projected opposite vertex
    logic signed [SW-1:0] rlo_reg, rhi_reg, t_reg;
    logic signed [SW-1:0] rlo_next, rhi_next, t_next;
    logic signed [PW-1:0] xmin, xmax, ymin, ymax;

    always_comb
    begin
        xmin = (px1_reg < px0_reg) ? px1_reg : px0_reg;
        xmax = (px0_reg < px1_reg) ? px1_reg : px0_reg;
        ymin = (py1_reg < py0_reg) ? py1_reg : py0_reg;
        ymax = (py0_reg < py1_reg) ? py1_reg : py0_reg;
        rlo_next = SW'(xmin) + SW'(ymin);
        rhi_next = SW'(xmax) + SW'(ymax);
        t_next   = SW'(ptx_reg) + SW'(pty_reg);
    end

    // stage 3: triangle span is [min(t,0), max(t,0)]
    logic ok_reg;
    logic ok_next;

    assign ok_next = !((t_reg < rlo_reg && rlo_reg > 0) ||
                       (rhi_reg < t_reg && rhi_reg < 0));

    always_ff @(posedge clk)
    begin
        if (adv.load[0])
        begin
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            rx0_reg <= rx0_next;
            rx1_reg <= rx1_next;
            ry0_reg <= ry0_next;
            ry1_reg <= ry1_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
        end
        if (adv.load[1])
        begin
            px0_reg <= px0_next;
            px1_reg <= px1_next;
            py0_reg <= py0_next;
            py1_reg <= py1_next;
            ptx_reg <= ptx_next;
            pty_reg <= pty_next;
        end
        if (adv.load[2])
        begin
            rlo_reg <= rlo_next;
            rhi_reg <= rhi_next;
            t_reg   <= t_next;
        end
        if (adv.load[3])
        begin
            ok_reg <= ok_next;
        end
    end

    assign ok = ok_reg;

endmodule

// ----- rtl/triangle_rectangle_overlap_test.sv -----
// Top level of the triangle/rectangle overlap test: pipeline control and edge lanes.
//
//   channel   role    payload                                   handshake
//   pair      sink    three vertices, rectangle bounds (x/y)    valid/ready
//   verdict   source  overlap                                   valid/ready
//
// Four register stages: differences, products (18 multipliers, the deepest
// path), span sums, span compares. One pair is taken per cycle while
// pair.ready is high. Each stage loads whenever it is empty or the stage after
// it moves, so bubbles fill up while the output stalls and pair.ready drops
// only when all four stages hold transactions. rst_n clears the stage valid bits.
`include "triangle_rectangle_overlap_test_defines.svh"

module triangle_rectangle_overlap_test #(
    parameter int COORD_BITS = trov_pkg::COORD_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    trov_pair_if.sink      pair,
    trov_verdict_if.source verdict
);

    localparam int S = trov_pkg::STAGES;

    logic [S-1:0]        valid_reg;
    logic [S-1:0]        valid_next;
    logic [S-1:0]        stage_rdy;
    trov_pkg::trov_adv_t adv;
    logic                bbox_ok, ok_ab, ok_bc, ok_ca;

    always_comb
    begin
        stage_rdy[S-1] = !valid_reg[S-1] || verdict.ready;
        for (int k = S - 2; k >= 0; k--)
        begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
        valid_next[0] = pair.valid;
        for (int k = 1; k < S; k++)
        begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    assign adv.load = stage_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < S; k++)
            begin
                if (stage_rdy[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign pair.ready    = stage_rdy[0];
    assign verdict.valid = valid_reg[S-1];
    assign verdict.overlap = bbox_ok & ok_ab & ok_bc & ok_ca;

    trov_bbox #(.COORD_BITS(COORD_BITS)) u_bbox (
        .clk (clk),
        .a_x (pair.vertex_a_x), .a_y (pair.vertex_a_y),
        .b_x (pair.vertex_b_x), .b_y (pair.vertex_b_y),
        .c_x (pair.vertex_c_x), .c_y (pair.vertex_c_y),
        .x0  (pair.rect_min_x), .x1  (pair.rect_max_x),
        .y0  (pair.rect_min_y), .y1  (pair.rect_max_y),
        .adv (adv),
        .ok  (bbox_ok)
    );

    // edge A->B, opposite C
    trov_edge #(.COORD_BITS(COORD_BITS)) u_edge_ab (
        .clk (clk),
        .s_x (pair.vertex_a_x), .s_y (pair.vertex_a_y),
        .e_x (pair.vertex_b_x), .e_y (pair.vertex_b_y),
        .o_x (pair.vertex_c_x), .o_y (pair.vertex_c_y),
        .x0  (pair.rect_min_x), .x1  (pair.rect_max_x),
        .y0  (pair.rect_min_y), .y1  (pair.rect_max_y),
        .adv (adv),
        .ok  (ok_ab)
    );

    // edge B->C, opposite A
    trov_edge #(.COORD_BITS(COORD_BITS)) u_edge_bc (
        .clk (clk),
        .s_x (pair.vertex_b_x), .s_y (pair.vertex_b_y),
        .e_x (pair.vertex_c_x), .e_y (pair.vertex_c_y),
        .o_x (pair.vertex_a_x), .o_y (pair.vertex_a_y),
        .x0  (pair.rect_min_x), .x1  (pair.rect_max_x),
        .y0  (pair.rect_min_y), .y1  (pair.rect_max_y),
        .adv (adv),
        .ok  (ok_bc)
    );

    // edge C->A, opposite B
    trov_edge #(.COORD_BITS(COORD_BITS)) u_edge_ca (
        .clk (clk),
        .s_x (pair.vertex_c_x), .s_y (pair.vertex_c_y),
        .e_x (pair.vertex_a_x), .e_y (pair.vertex_a_y),
        .o_x (pair.vertex_b_x), .o_y (pair.vertex_b_y),
        .x0  (pair.rect_min_x), .x1  (pair.rect_max_x),
        .y0  (pair.rect_min_y), .y1  (pair.rect_max_y),
        .adv (adv),
        .ok  (ok_ca)
    );

    // backpressure reaches the input only with every stage full and the output stalled
    `TROV_ASSERT_NOW(a_ready_only_when_full, clk, rst_n, !pair.ready, (&valid_reg) && !verdict.ready, "input stalled with room in the pipeline")

    // occupancy grows by one on an input transaction with no output transaction
    `TROV_ASSERT_NEXT(a_fill_count, clk, rst_n, pair.valid && pair.ready && !(verdict.valid && verdict.ready), $countones(valid_reg) == $past($countones(valid_reg)) + 1, "transaction lost on entry")

    // occupancy shrinks by one on an output transaction with no input transaction
    `TROV_ASSERT_NEXT(a_drain_count, clk, rst_n, verdict.valid && verdict.ready && !(pair.valid && pair.ready), $countones(valid_reg) + 1 == $past($countones(valid_reg)), "transaction repeated or lost on exit")

endmodule

// ----- bench/triangle_rectangle_overlap_test_tb.sv -----
// Self-checking testbench for the triangle/rectangle overlap test block.
`timescale 1ns / 100ps

module triangle_rectangle_overlap_test_tb;

    localparam int COORD_BITS = trov_pkg::COORD_BITS_DEFAULT;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SPAN_W = 2 * DIFF_W + 2;
    localparam int RANDOM_PAIRS = 1000;
    localparam int MAX_REPORTS = 10;
    localparam int EXTREMES [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [SPAN_W-1:0] span_t;

    typedef struct {
        coord_t vertex_a_x;
        coord_t vertex_a_y;
        coord_t vertex_b_x;
        coord_t vertex_b_y;
        coord_t vertex_c_x;
        coord_t vertex_c_y;
        coord_t rect_min_x;
        coord_t rect_max_x;
        coord_t rect_min_y;
        coord_t rect_max_y;
    } pair_t;

    typedef enum {CHECK_MODEL, CHECK_HIT, CHECK_MISS} check_t;
    typedef enum {ACCEPT_ALL, ACCEPT_COIN, ACCEPT_SPARSE, ACCEPT_CADENCE} accept_style_t;

    typedef struct {
        pair_t  pair;
        check_t check;
    } directed_row_t;

    logic clk;
    logic rst_n;

    trov_pair_if #(.COORD_BITS(COORD_BITS)) pair_if ();
    trov_verdict_if verdict_if ();

    triangle_rectangle_overlap_test #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pair    (pair_if),
        .verdict (verdict_if)
    );

    check_t        check_modes [$];
    bit            verdicts_due [$];
    directed_row_t directed_rows [$];
    int            mismatches = 0;
    int            burst_left = 0;
    accept_style_t accept_style = ACCEPT_ALL;
    int            style_left = 0;
    int            cadence_count = 0;

    // ---------------------------------------------------------------
    // overlap predictor
    // ---------------------------------------------------------------
    function automatic span_t span_min(span_t p, span_t q);
        return (q < p) ? q : p;
    endfunction

    function automatic span_t span_max(span_t p, span_t q);
        return (p < q) ? q : p;
    endfunction

    function automatic coord_t coord_min3(coord_t p, coord_t q, coord_t r);
        coord_t m;
        m = (p < q) ? p : q;
        return (m < r) ? m : r;
    endfunction

    function automatic coord_t coord_max3(coord_t p, coord_t q, coord_t r);
        coord_t m;
        m = (p > q) ? p : q;
        return (m > r) ? m : r;
    endfunction

    // edge s->e with opposite vertex o; 1 when its normal does not separate
    function automatic bit edge_holds(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                      coord_t ox, coord_t oy, pair_t p);
        diff_t nx, ny, rx0, rx1, ry0, ry1, tx, ty;
        span_t px0, px1, py0, py1, rlo, rhi, t, tlo, thi;
        nx  = sy - ey;
        ny  = ex - sx;
        rx0 = p.rect_min_x - sx;
        rx1 = p.rect_max_x - sx;
        ry0 = p.rect_min_y - sy;
        ry1 = p.rect_max_y - sy;
        tx  = ox - sx;
        ty  = oy - sy;
        px0 = nx * rx0;
        px1 = nx * rx1;
        py0 = ny * ry0;
        py1 = ny * ry1;
        rlo = span_min(px0, px1) + span_min(py0, py1);
        rhi = span_max(px0, px1) + span_max(py0, py1);
        t   = nx * tx + ny * ty;
        tlo = span_min(t, '0);
        thi = span_max(t, '0);
        return !((thi < rlo) || (rhi < tlo));
    endfunction

    function automatic bit overlap_of(pair_t p);
        if (coord_min3(p.vertex_a_x, p.vertex_b_x, p.vertex_c_x) > p.rect_max_x ||
            coord_max3(p.vertex_a_x, p.vertex_b_x, p.vertex_c_x) < p.rect_min_x ||
            coord_min3(p.vertex_a_y, p.vertex_b_y, p.vertex_c_y) > p.rect_max_y ||
            coord_max3(p.vertex_a_y, p.vertex_b_y, p.vertex_c_y) < p.rect_min_y)
            return 1'b0;
        return edge_holds(p.vertex_a_x, p.vertex_a_y, p.vertex_b_x, p.vertex_b_y,
                          p.vertex_c_x, p.vertex_c_y, p) &&
               edge_holds(p.vertex_b_x, p.vertex_b_y, p.vertex_c_x, p.vertex_c_y,
                          p.vertex_a_x, p.vertex_a_y, p) &&
               edge_holds(p.vertex_c_x, p.vertex_c_y, p.vertex_a_x, p.vertex_a_y,
                          p.vertex_b_x, p.vertex_b_y, p);
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic pair_t make_pair(int ax, int ay, int bx, int by, int cx, int cy,
                                        int x0, int x1, int y0, int y1);
        pair_t p;
        p.vertex_a_x = coord_t'(ax);
        p.vertex_a_y = coord_t'(ay);
        p.vertex_b_x = coord_t'(bx);
        p.vertex_b_y = coord_t'(by);
        p.vertex_c_x = coord_t'(cx);
        p.vertex_c_y = coord_t'(cy);
        p.rect_min_x = coord_t'(x0);
        p.rect_max_x = coord_t'(x1);
        p.rect_min_y = coord_t'(y0);
        p.rect_max_y = coord_t'(y1);
        return p;
    endfunction

    function automatic int near(int base, int spread);
        return base + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic int extreme_coord();
        return EXTREMES[$urandom_range(0, 6)];
    endfunction

    // mostly clustered shapes so the edge tests decide; some raw noise and corners
    function automatic pair_t random_pair();
        int pick, spread, cx, cy, x0, x1, y0, y1, swap;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return make_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom);
        if (pick < 35)
            return make_pair(extreme_coord(), extreme_coord(), extreme_coord(),
                             extreme_coord(), extreme_coord(), extreme_coord(),
                             extreme_coord(), extreme_coord(), extreme_coord(),
                             extreme_coord());
        case ($urandom_range(0, 2))
            0:       spread = 4;
            1:       spread = 100;
            default: spread = 3000;
        endcase
        cx = $urandom_range(0, 65535) - 32768;
        cy = $urandom_range(0, 65535) - 32768;
        x0 = near(cx, spread);
        x1 = x0 + int'($urandom_range(0, spread));
        y0 = near(cy, spread);
        y1 = y0 + int'($urandom_range(0, spread));
        if ($urandom_range(0, 7) == 0)
        begin
            swap = x0;
            x0 = x1;
            x1 = swap;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            swap = y0;
            y0 = y1;
            y1 = swap;
        end
        return make_pair(near(cx, spread), near(cy, spread), near(cx, spread),
                         near(cy, spread), near(cx, spread), near(cy, spread),
                         x0, x1, y0, y1);
    endfunction

    // one transaction on the pair channel, with bursty gaps
    task automatic present_pair(input pair_t p, input check_t check);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                @(negedge clk);
                pair_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        check_modes.push_back(check);
        pair_if.valid      <= 1'b1;
        pair_if.vertex_a_x <= p.vertex_a_x;
        pair_if.vertex_a_y <= p.vertex_a_y;
        pair_if.vertex_b_x <= p.vertex_b_x;
        pair_if.vertex_b_y <= p.vertex_b_y;
        pair_if.vertex_c_x <= p.vertex_c_x;
        pair_if.vertex_c_y <= p.vertex_c_y;
        pair_if.rect_min_x <= p.rect_min_x;
        pair_if.rect_max_x <= p.rect_max_x;
        pair_if.rect_min_y <= p.rect_min_y;
        pair_if.rect_max_y <= p.rect_max_y;
        do
            @(posedge clk);
        while (!pair_if.ready);
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------
    // clock, reset, timeout
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // verdict receiver: stall style redrawn at random, accepting on all, random, sparse or cadenced cycles
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            accept_style = accept_style_t'($urandom_range(0, 3));
            style_left = $urandom_range(20, 200);
        end
        else
            style_left--;
        cadence_count++;
        case (accept_style)
            ACCEPT_ALL:     verdict_if.ready <= 1'b1;
            ACCEPT_COIN:    verdict_if.ready <= 1'($urandom_range(0, 1));
            ACCEPT_SPARSE:  verdict_if.ready <= ($urandom_range(0, 3) == 0);
            default:        verdict_if.ready <= (cadence_count % 4 != 3);
        endcase
    end

    // ---------------------------------------------------------------
    // scoreboard: predict on pair transaction, compare on verdict transaction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        pair_t  seen;
        check_t check;
        bit     want;
        if (rst_n)
        begin
            if (pair_if.valid && pair_if.ready)
            begin
                seen.vertex_a_x = pair_if.vertex_a_x;
                seen.vertex_a_y = pair_if.vertex_a_y;
                seen.vertex_b_x = pair_if.vertex_b_x;
                seen.vertex_b_y = pair_if.vertex_b_y;
                seen.vertex_c_x = pair_if.vertex_c_x;
                seen.vertex_c_y = pair_if.vertex_c_y;
                seen.rect_min_x = pair_if.rect_min_x;
                seen.rect_max_x = pair_if.rect_max_x;
                seen.rect_min_y = pair_if.rect_min_y;
                seen.rect_max_y = pair_if.rect_max_y;
                check = check_modes.pop_front();
                case (check)
                    CHECK_HIT:  verdicts_due.push_back(1'b1);
                    CHECK_MISS: verdicts_due.push_back(1'b0);
                    default:    verdicts_due.push_back(overlap_of(seen));
                endcase
            end
            if (verdict_if.valid && verdict_if.ready)
            begin
                if (verdicts_due.size() == 0)
                    note_mismatch($sformatf("unexpected verdict, overlap %0b",
                                            verdict_if.overlap));
                else
                begin
                    want = verdicts_due.pop_front();
                    if (verdict_if.overlap !== want)
                        note_mismatch($sformatf("overlap expected %0b, got %0b",
                                                want, verdict_if.overlap));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        directed_row_t row;
        rst_n = 1'b0;
        pair_if.valid = 1'b0;
        pair_if.vertex_a_x = '0;
        pair_if.vertex_a_y = '0;
        pair_if.vertex_b_x = '0;
        pair_if.vertex_b_y = '0;
        pair_if.vertex_c_x = '0;
        pair_if.vertex_c_y = '0;
        pair_if.rect_min_x = '0;
        pair_if.rect_max_x = '0;
        pair_if.rect_min_y = '0;
        pair_if.rect_max_y = '0;
        verdict_if.ready = 1'b0;

        // all-zero point on point rectangle
        directed_rows.push_back('{make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), CHECK_HIT});
        // rectangle inside triangle and triangle around rectangle
        directed_rows.push_back('{make_pair(0, 0, 10, 0, 0, 10, 2, 4, 2, 4), CHECK_HIT});
        directed_rows.push_back('{make_pair(-100, -100, 100, -100, 0, 100, -5, 5, -5, 5),
                                  CHECK_HIT});
        // bounding box rejects on x and on y
        directed_rows.push_back('{make_pair(-50, -50, -40, -50, -45, -40, 0, 10, 0, 10),
                                  CHECK_MISS});
        directed_rows.push_back('{make_pair(0, 20, 10, 20, 5, 30, 0, 10, 0, 10),
                                  CHECK_MISS});
        // vertex touching rectangle corner
        directed_rows.push_back('{make_pair(10, 10, 20, 10, 20, 20, 0, 10, 0, 10),
                                  CHECK_HIT});
        // boxes meet, hypotenuse separates / touches
        directed_rows.push_back('{make_pair(0, 0, 10, 0, 0, 10, 8, 12, 8, 12), CHECK_MODEL});
        directed_rows.push_back('{make_pair(0, 0, 10, 0, 0, 10, 5, 7, 5, 7), CHECK_MODEL});
        // clockwise winding
        directed_rows.push_back('{make_pair(0, 0, 0, 10, 10, 0, 2, 4, 2, 4), CHECK_HIT});
        // full-range extremes
        directed_rows.push_back('{make_pair(-32768, -32768, 32767, -32768, -32768, 32767,
                                            -32768, 32767, -32768, 32767), CHECK_HIT});
        directed_rows.push_back('{make_pair(-32768, -32768, 32767, -32768, -32768, 32767,
                                            32767, 32767, 32767, 32767), CHECK_MODEL});
        directed_rows.push_back('{make_pair(32767, 32767, -32768, 32767, 32767, -32768,
                                            -32768, -32768, -32768, -32768), CHECK_MODEL});
        directed_rows.push_back('{make_pair(-32768, -32768, -32767, -32768, -32768, -32767,
                                            -32768, -32768, -32768, -32768), CHECK_HIT});
        // degenerate triangle: single point inside / outside
        directed_rows.push_back('{make_pair(3, 3, 3, 3, 3, 3, 0, 5, 0, 5), CHECK_HIT});
        directed_rows.push_back('{make_pair(6, 6, 6, 6, 6, 6, 0, 5, 0, 5), CHECK_MISS});
        // collinear vertices passing by and through the rectangle
        directed_rows.push_back('{make_pair(0, 8, 8, 0, 4, 4, 0, 3, 0, 3), CHECK_MODEL});
        directed_rows.push_back('{make_pair(-10, -10, 10, 10, 0, 0, -2, 2, -2, 2),
                                  CHECK_MODEL});
        // swapped bounds
        directed_rows.push_back('{make_pair(0, 0, 10, 0, 0, 10, 6, 4, 1, 2), CHECK_MODEL});
        directed_rows.push_back('{make_pair(-20, -20, 20, -20, 0, 20, 5, -5, 5, -5),
                                  CHECK_MODEL});
        // zero-height rectangle crossing the triangle
        directed_rows.push_back('{make_pair(0, 0, 10, 0, 0, 10, -5, 20, 3, 3), CHECK_MODEL});
        // alternating bit patterns
        directed_rows.push_back('{make_pair('h5555, 'haaaa, 'haaaa, 'h5555, 'h5555, 'h5555,
                                            'haaaa, 'h5555, 'haaaa, 'h5555), CHECK_MODEL});

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            present_pair(row.pair, row.check);
        end
        repeat (RANDOM_PAIRS) present_pair(random_pair(), CHECK_MODEL);

        @(negedge clk);
        pair_if.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (2 * trov_pkg::STAGES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
